// ----- hw/rtl/qte_pkg.sv -----
package qte_pkg;

    localparam int Q_W       = 16;
    localparam int ROLL_W    = 18;
    localparam int PITCH_W   = 15;
    localparam int YAW_W     = 16;
    localparam int DW        = 38;
    localparam int AW        = 36;
    localparam int ACC_FRAC  = 30;
    localparam int TAB_LEN   = 24;
    localparam int MUL_LO_W  = 18;
    localparam int GAIN_W    = 30;
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    function automatic logic signed [AW-1:0] atan_q30(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:       v = 36'sd843314856;
            1:       v = 36'sd497837829;
            2:       v = 36'sd263043836;
            3:       v = 36'sd133525158;
            4:       v = 36'sd67021686;
            5:       v = 36'sd33543515;
            6:       v = 36'sd16775850;
            7:       v = 36'sd8388437;
            8:       v = 36'sd4194282;
            9:       v = 36'sd2097149;
            10:      v = 36'sd1048575;
            11:      v = 36'sd524287;
            12:      v = 36'sd262143;
            13:      v = 36'sd131071;
            14:      v = 36'sd65535;
            15:      v = 36'sd32767;
            16:      v = 36'sd16383;
            17:      v = 36'sd8191;
            18:      v = 36'sd4095;
            19:      v = 36'sd2047;
            20:      v = 36'sd1023;
            21:      v = 36'sd511;
            22:      v = 36'sd255;
            23:      v = 36'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/qte_cell.sv -----
module qte_cell #(
    parameter int IDX = 0,
    parameter int PW  = 1
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [qte_pkg::DW-1:0]     x_in,
    input  logic signed [qte_pkg::DW-1:0]     y_in,
    input  logic signed [qte_pkg::AW-1:0]     acc_in,
    input  logic        [PW-1:0]              pay_in,
    output logic signed [qte_pkg::DW-1:0]     x_out,
    output logic signed [qte_pkg::DW-1:0]     y_out,
    output logic signed [qte_pkg::AW-1:0]     acc_out,
    output logic        [PW-1:0]              pay_out
);

    localparam logic signed [qte_pkg::AW-1:0] ANG = qte_pkg::atan_q30(IDX);

    logic signed [qte_pkg::DW-1:0] x_reg, y_reg, dx, dy;
    logic signed [qte_pkg::AW-1:0] acc_reg;
    logic        [PW-1:0]          pay_reg;

    assign dx = y_in >>> IDX;
    assign dy = x_in >>> IDX;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (y_in > 0)
            begin
                x_reg   <= x_in + dx;
                y_reg   <= y_in - dy;
                acc_reg <= acc_in + ANG;
            end
            else
            begin
                x_reg   <= x_in - dx;
                y_reg   <= y_in + dy;
                acc_reg <= acc_in - ANG;
            end
            pay_reg <= pay_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;
    assign pay_out = pay_reg;

endmodule

// ----- hw/rtl/qte_cordic.sv -----
module qte_cordic #(
    parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF,
    parameter int SW    = 1
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [qte_pkg::DW-1:0]     y_in,
    input  logic signed [qte_pkg::DW-1:0]     x_in,
    input  logic        [SW-1:0]              side_in,
    output logic signed [qte_pkg::AW-1:0]     ang,
    output logic signed [qte_pkg::DW-1:0]     kmag,
    output logic        [SW-1:0]              side_out
);

    localparam int PW = SW + 1;
    localparam logic signed [qte_pkg::AW-1:0] HALF_PI2 = qte_pkg::atan_q30(0) <<< 1;

    logic signed [qte_pkg::DW-1:0] x_reg, y_reg;
    logic signed [qte_pkg::AW-1:0] acc_reg;
    logic        [PW-1:0]          pay_reg;

    logic signed [qte_pkg::DW-1:0] xs   [0:STEPS];
    logic signed [qte_pkg::DW-1:0] ys   [0:STEPS];
    logic signed [qte_pkg::AW-1:0] accs [0:STEPS];
    logic        [PW-1:0]          pays [0:STEPS];

    // quadrant fold for negative x, zero vector flagged
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg   <= y_in;
                    y_reg   <= -x_in;
                    acc_reg <= HALF_PI2;
                end
                else
                begin
                    x_reg   <= -y_in;
                    y_reg   <= x_in;
                    acc_reg <= -HALF_PI2;
                end
            end
            else
            begin
                x_reg   <= x_in;
                y_reg   <= y_in;
                acc_reg <= '0;
            end
            pay_reg <= {(x_in == 0) && (y_in == 0), side_in};
        end
    end

    assign xs[0]   = x_reg;
    assign ys[0]   = y_reg;
    assign accs[0] = acc_reg;
    assign pays[0] = pay_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        qte_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (xs[i]),
            .y_in    (ys[i]),
            .acc_in  (accs[i]),
            .pay_in  (pays[i]),
            .x_out   (xs[i+1]),
            .y_out   (ys[i+1]),
            .acc_out (accs[i+1]),
            .pay_out (pays[i+1])
        );
    end

    assign ang      = pays[STEPS][SW] ? '0 : accs[STEPS];
    assign kmag     = pays[STEPS][SW] ? '0 : xs[STEPS];
    assign side_out = pays[STEPS][SW-1:0];

endmodule

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Quaternion to ZYX Euler angle converter.
// Input channel quat_*: one attitude quaternion (w,x,y,z), signed Q2.14,
// transferred when quat_valid and quat_ready are both high.
// Output channel euler_*: roll, pitch and yaw in radians scaled by
// 2^ANGLE_FRAC_BITS, plus gimbal_lock, transferred on euler_valid and
// euler_ready.
// Pipeline: product stage, yaw/roll CORDIC rows of a fold stage plus
// CORDIC_STEPS cells, two gain multiply stages, pitch CORDIC row of the
// same length, output register.
// Throughput: one quaternion per cycle unless stalled; all rows advance together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and quat_ready drops; it rises as soon as the result is taken.
// Reset clears all valid flags; the data registers are not reset.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS    = qte_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  quat_valid,
    output logic                                  quat_ready,
    input  logic signed [qte_pkg::Q_W-1:0]        quat_w,
    input  logic signed [qte_pkg::Q_W-1:0]        quat_x,
    input  logic signed [qte_pkg::Q_W-1:0]        quat_y,
    input  logic signed [qte_pkg::Q_W-1:0]        quat_z,
    output logic                                  euler_valid,
    input  logic                                  euler_ready,
    output logic signed [qte_pkg::ROLL_W-1:0]     roll_angle,
    output logic signed [qte_pkg::PITCH_W-1:0]    pitch_angle,
    output logic signed [qte_pkg::YAW_W-1:0]      yaw_angle,
    output logic                                  gimbal_lock
);

    localparam int DW  = qte_pkg::DW;
    localparam int AW  = qte_pkg::AW;
    localparam int LAT = 2 * CORDIC_STEPS + 6;
    localparam int SH  = qte_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] RND = AW'(1) <<< (SH - 1);
    localparam int LO_W  = qte_pkg::MUL_LO_W;
    localparam int HI_W  = DW - LO_W;
    localparam int PLO_W = LO_W + qte_pkg::GAIN_W;
    localparam int PHI_W = HI_W + qte_pkg::GAIN_W;
    localparam int SUM_W = PHI_W + LO_W;
    localparam int PS_W  = 3 * AW + 2;
    localparam int YS_W  = DW + 1;

    logic [LAT-1:0] vld_reg, vld_next;
    logic           adv;

    assign adv        = !vld_reg[LAT-1] || euler_ready;
    assign quat_ready = adv;
    assign euler_valid = vld_reg[LAT-1];

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], quat_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // products
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, wy_reg, xz_reg, yz_reg, wx_reg;
    logic signed [qte_pkg::Q_W-1:0] w1_reg, x1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= 32'(quat_w) * 32'(quat_w);
            xx_reg <= 32'(quat_x) * 32'(quat_x);
            yy_reg <= 32'(quat_y) * 32'(quat_y);
            zz_reg <= 32'(quat_z) * 32'(quat_z);
            xy_reg <= 32'(quat_x) * 32'(quat_y);
            wz_reg <= 32'(quat_w) * 32'(quat_z);
            wy_reg <= 32'(quat_w) * 32'(quat_y);
            xz_reg <= 32'(quat_x) * 32'(quat_z);
            yz_reg <= 32'(quat_y) * 32'(quat_z);
            wx_reg <= 32'(quat_w) * 32'(quat_x);
            w1_reg <= quat_w;
            x1_reg <= quat_x;
        end
    end

    logic signed [DW-1:0] t0, t1, a, b, c, d, e;
    logic                 lock;

    assign t0   = DW'(xx_reg) - DW'(zz_reg);
    assign t1   = DW'(ww_reg) - DW'(yy_reg);
    assign a    = t0 + t1;
    assign b    = (DW'(xy_reg) + DW'(wz_reg)) <<< 1;
    assign c    = (DW'(wy_reg) - DW'(xz_reg)) <<< 1;
    assign d    = (DW'(yz_reg) + DW'(wx_reg)) <<< 1;
    assign e    = t1 - t0;
    assign lock = (a == 0) && (b == 0);

    logic signed [AW-1:0] yaw_a, roll_a, alt_a;
    logic signed [DW-1:0] yaw_k;
    logic        [YS_W-1:0] yaw_s;

    qte_cordic #(.STEPS(CORDIC_STEPS), .SW(YS_W)) u_yaw (
        .clk      (clk),
        .en       (adv),
        .y_in     (b),
        .x_in     (a),
        .side_in  ({lock, c}),
        .ang      (yaw_a),
        .kmag     (yaw_k),
        .side_out (yaw_s)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_roll (
        .clk      (clk),
        .en       (adv),
        .y_in     (d),
        .x_in     (e),
        .side_in  (1'b0),
        .ang      (roll_a),
        .kmag     (),
        .side_out ()
    );

    qte_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_alt (
        .clk      (clk),
        .en       (adv),
        .y_in     (DW'(x1_reg)),
        .x_in     (DW'(w1_reg)),
        .side_in  (1'b0),
        .ang      (alt_a),
        .kmag     (),
        .side_out ()
    );

    // gain correction, split into two partial products
    logic [PLO_W-1:0]     plo_reg;
    logic [PHI_W-1:0]     phi_reg;
    logic signed [DW-1:0] mag_reg, c1_reg, c2_reg;
    logic [PS_W-1:0]      ps1_reg, ps2_reg;
    logic [SUM_W-1:0]     psum;

    assign psum = {phi_reg, {LO_W{1'b0}}} + SUM_W'(plo_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg <= PLO_W'(yaw_k[LO_W-1:0]) * PLO_W'(qte_pkg::INV_GAIN);
            phi_reg <= PHI_W'(yaw_k[DW-1:LO_W]) * PHI_W'(qte_pkg::INV_GAIN);
            c1_reg  <= yaw_s[DW-1:0];
            ps1_reg <= {yaw_s[DW], yaw_s[DW-1], yaw_a, roll_a, alt_a};
            mag_reg <= DW'(psum >> qte_pkg::ACC_FRAC);
            c2_reg  <= c1_reg;
            ps2_reg <= ps1_reg;
        end
    end

    logic signed [AW-1:0] pitch_a;
    logic [PS_W-1:0]      ps3;

    qte_cordic #(.STEPS(CORDIC_STEPS), .SW(PS_W)) u_pitch (
        .clk      (clk),
        .en       (adv),
        .y_in     (c2_reg),
        .x_in     (mag_reg),
        .side_in  (ps2_reg),
        .ang      (pitch_a),
        .kmag     (),
        .side_out (ps3)
    );

    logic                 f_lock, f_cneg;
    logic signed [AW-1:0] f_yaw, f_roll, f_alt, roll_q, roll_r, pitch_r, yaw_r;

    assign f_lock = ps3[PS_W-1];
    assign f_cneg = ps3[PS_W-2];
    assign f_yaw  = ps3[3*AW-1:2*AW];
    assign f_roll = ps3[2*AW-1:AW];
    assign f_alt  = ps3[AW-1:0];

    assign roll_q  = f_lock ? ((f_alt <<< 1) - (f_cneg ? -f_yaw : f_yaw)) : f_roll;
    assign roll_r  = (roll_q + RND) >>> SH;
    assign pitch_r = (pitch_a + RND) >>> SH;
    assign yaw_r   = (f_yaw + RND) >>> SH;

    logic signed [qte_pkg::ROLL_W-1:0]  roll_reg;
    logic signed [qte_pkg::PITCH_W-1:0] pitch_reg;
    logic signed [qte_pkg::YAW_W-1:0]   yaw_reg;
    logic                               lock_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= roll_r[qte_pkg::ROLL_W-1:0];
            pitch_reg <= pitch_r[qte_pkg::PITCH_W-1:0];
            yaw_reg   <= yaw_r[qte_pkg::YAW_W-1:0];
            lock_reg  <= f_lock;
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign gimbal_lock = lock_reg;

    a_lock_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid && gimbal_lock |-> yaw_angle == '0)
        else $error("yaw nonzero in gimbal lock");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_ready |=> vld_reg[0])
        else $error("accepted quaternion lost");

endmodule
